// ----- hdl/nrtp_pkg.sv -----
// shared types and constants of the nested region time profiler
// no dependencies; used by the top level, its checker and the bench
`timescale 1ns / 1ps

package nrtp_pkg;

	localparam int unsigned SLOT_COUNT_DEF  = 32;
	localparam int unsigned STACK_DEPTH_DEF = 128;

	localparam int unsigned SLOT_W = 5;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned DROP_W = 16;
	localparam logic [DROP_W-1:0] DROP_MAX = '1;

	typedef enum logic [1:0] {
		OP_ENTER = 2'd0,
		OP_EXIT  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE         = 2'd0,
		ST_ENTER_DROP   = 2'd1,
		ST_EXIT_IGNORED = 2'd2
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] calls;
		logic [TIME_W-1:0] total;
		logic [TIME_W-1:0] excl;
	} stats_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] child;
	} frame_t;

endpackage

// ----- hdl/nested_region_time_profiler.sv -----
// nested region time profiler: call stack and per-slot statistics in memories
// depends on nrtp_pkg
`timescale 1ns / 1ps

// Usage
//   A request (operation, slot, timestamp) is taken at a rising edge with start
//   high and busy low. Operations: enter pushes a frame, exit pops the top frame
//   and credits its slot and parent, read reports a slot, clear wipes statistics
//   and the stack.
//   Each request gives exactly one result on status, result_slot, num_calls,
//   total_time, self_time and elapsed_time, shown for one cycle with done high.
//   The request and its memory reads are registered in the request stage, and
//   the result in the output registers after it. busy is high for the one cycle
//   in which the request's memory reads return and the read-modify-write of the
//   slot statistics memory and the frame stack memory completes.
//   The top frame lives in registers; the frames below it live in the stack
//   memory, so an exit needs only one read of the stack (the new top).
//   Reset empties the stack, clears the dropped-enter count and marks every slot
//   as unwritten, so it reads as zero; no clearing pass is needed, and a clear
//   request does the same.
//   The receiver cannot stall: a result not taken in its cycle is gone.
module nested_region_time_profiler #(
	parameter int unsigned SLOT_COUNT  = nrtp_pkg::SLOT_COUNT_DEF,
	parameter int unsigned STACK_DEPTH = nrtp_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [nrtp_pkg::SLOT_W-1:0] slot,
	input  logic [nrtp_pkg::TIME_W-1:0] timestamp,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [nrtp_pkg::SLOT_W-1:0] result_slot,
	output logic [nrtp_pkg::TIME_W-1:0] num_calls,
	output logic [nrtp_pkg::TIME_W-1:0] total_time,
	output logic [nrtp_pkg::TIME_W-1:0] self_time,
	output logic [nrtp_pkg::TIME_W-1:0] elapsed_time
);
	import nrtp_pkg::*;

	localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned FA_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned SA_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// memories
	stats_t stats_mem [SLOT_COUNT];
	frame_t frame_mem [STACK_DEPTH];
	stats_t stats_rd_q;
	frame_t frame_rd_q;

	// control state
	logic [SLOT_COUNT-1:0] slot_vld_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic [DROP_W-1:0]     dropped_q;
	frame_t                top_q;

	// request stage
	logic                vld_s1;
	op_t                 op_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [SA_W-1:0]     addr_s1;
	logic                in_range_s1;
	logic [TIME_W-1:0]   ts_s1;
	logic [TIME_W-1:0]   elapsed_s1;
	logic [TIME_W-1:0]   self_s1;

	// output registers
	logic                done_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   result_slot_q;
	logic [TIME_W-1:0]   num_calls_q;
	logic [TIME_W-1:0]   total_time_q;
	logic [TIME_W-1:0]   self_time_q;
	logic [TIME_W-1:0]   elapsed_time_q;

	logic              accept;
	op_t               op_in;
	logic [SLOT_W-1:0] eff_slot;
	logic [TIME_W-1:0] elapsed_in;
	logic [FA_W-1:0]   pop_addr;
	logic [FA_W-1:0]   push_addr;
	logic              full;
	logic              exit_ignored;
	logic              exit_ok;
	logic              enter_ok;
	stats_t            stats_old;
	stats_t            stats_new;
	status_t           res_status;
	logic [SLOT_W-1:0] res_slot;
	stats_t            res_stats;
	logic [TIME_W-1:0] res_elapsed;

	assign busy   = vld_s1;
	assign accept = start && !busy;
	assign op_in  = op_t'(operation);

	// an exit reports the slot of the frame it pops
	assign eff_slot   = (op_in == OP_EXIT) ? top_q.slot : slot;
	assign elapsed_in = timestamp - top_q.start;
	assign pop_addr   = FA_W'(depth_q - DEPTH_W'(2));
	assign push_addr  = FA_W'(depth_q - DEPTH_W'(1));

	assign full         = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign exit_ignored = (dropped_q != '0) || (depth_q == '0);
	assign exit_ok      = vld_s1 && (op_s1 == OP_EXIT) && !exit_ignored;
	assign enter_ok     = vld_s1 && (op_s1 == OP_ENTER) && !full;

	// never-written slots read as zero
	assign stats_old = (in_range_s1 && slot_vld_q[addr_s1]) ? stats_rd_q : '0;

	always_comb begin
		stats_new       = stats_old;
		stats_new.calls = stats_old.calls + TIME_W'(1);
		stats_new.total = stats_old.total + elapsed_s1;
		stats_new.excl  = stats_old.excl + self_s1;
	end

	// result of the request in flight
	always_comb begin
		res_status  = ST_DONE;
		res_slot    = slot_s1;
		res_stats   = stats_old;
		res_elapsed = '0;
		unique case (op_s1)
			OP_ENTER: begin
				if (full) begin
					res_status = ST_ENTER_DROP;
				end
			end
			OP_EXIT: begin
				if (exit_ignored) begin
					res_status = ST_EXIT_IGNORED;
					res_slot   = '0;
					res_stats  = '0;
				end else begin
					res_elapsed = elapsed_s1;
					if (in_range_s1) begin
						res_stats = stats_new;
					end
				end
			end
			OP_READ: begin
			end
			OP_CLEAR: begin
				res_slot  = '0;
				res_stats = '0;
			end
			default: begin
			end
		endcase
	end

	// memory ports and payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			stats_rd_q  <= stats_mem[SA_W'(eff_slot)];
			frame_rd_q  <= frame_mem[pop_addr];
			op_s1       <= op_in;
			slot_s1     <= eff_slot;
			addr_s1     <= SA_W'(eff_slot);
			in_range_s1 <= (9'(eff_slot) < 9'(SLOT_COUNT));
			ts_s1       <= timestamp;
			elapsed_s1  <= elapsed_in;
			self_s1     <= (elapsed_in >= top_q.child) ? elapsed_in - top_q.child : '0;
		end
		if (exit_ok && in_range_s1) begin
			stats_mem[addr_s1] <= stats_new;
		end
		// the old top frame moves down into the stack memory
		if (enter_ok && depth_q != '0) begin
			frame_mem[push_addr] <= top_q;
		end
		if (enter_ok) begin
			top_q.slot  <= slot_s1;
			top_q.start <= ts_s1;
			top_q.child <= '0;
		end else if (exit_ok && depth_q > DEPTH_W'(1)) begin
			top_q.slot  <= frame_rd_q.slot;
			top_q.start <= frame_rd_q.start;
			top_q.child <= frame_rd_q.child + elapsed_s1;
		end
		if (vld_s1) begin
			status_q       <= res_status;
			result_slot_q  <= res_slot;
			num_calls_q    <= res_stats.calls;
			total_time_q   <= res_stats.total;
			self_time_q    <= res_stats.excl;
			elapsed_time_q <= res_elapsed;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			done_q     <= 1'b0;
			slot_vld_q <= '0;
			depth_q    <= '0;
			dropped_q  <= '0;
		end else begin
			vld_s1 <= accept;
			done_q <= vld_s1;
			if (vld_s1) begin
				unique case (op_s1)
					OP_ENTER: begin
						if (full) begin
							if (dropped_q != DROP_MAX) begin
								dropped_q <= dropped_q + DROP_W'(1);
							end
						end else begin
							depth_q <= depth_q + DEPTH_W'(1);
						end
					end
					OP_EXIT: begin
						if (dropped_q != '0) begin
							dropped_q <= dropped_q - DROP_W'(1);
						end else if (depth_q != '0) begin
							depth_q <= depth_q - DEPTH_W'(1);
							if (in_range_s1) begin
								slot_vld_q[addr_s1] <= 1'b1;
							end
						end
					end
					OP_READ: begin
					end
					OP_CLEAR: begin
						slot_vld_q <= '0;
						depth_q    <= '0;
						dropped_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_slot  = result_slot_q;
	assign num_calls    = num_calls_q;
	assign total_time   = total_time_q;
	assign self_time    = self_time_q;
	assign elapsed_time = elapsed_time_q;

endmodule

// ----- hdl/nrtp_checker.sv -----
// port-level checks of the nested region time profiler, bound to the top level
// depends on nrtp_pkg
`timescale 1ns / 1ps

module nrtp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [nrtp_pkg::SLOT_W-1:0] result_slot,
	input logic [nrtp_pkg::TIME_W-1:0] num_calls,
	input logic [nrtp_pkg::TIME_W-1:0] elapsed_time
);
	import nrtp_pkg::*;

	// every accepted request gets its result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result missing two cycles after request");

	// busy is high, and done low, in the cycle after a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("busy not raised after request");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_DONE || status == ST_ENTER_DROP || status == ST_EXIT_IGNORED)
		else $error("status code out of range");

	// ignored exit reports nothing
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EXIT_IGNORED |->
			result_slot == '0 && num_calls == '0 && elapsed_time == '0)
		else $error("ignored exit carries data");

	a_drop_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ENTER_DROP |-> elapsed_time == '0)
		else $error("dropped enter reports elapsed time");

endmodule

bind nested_region_time_profiler nrtp_checker u_nrtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.result_slot  (result_slot),
	.num_calls    (num_calls),
	.elapsed_time (elapsed_time)
);

// ----- bench/tb_nested_region_time_profiler.sv -----
// self-checking bench for nested_region_time_profiler: table-driven and random requests
// depends on nrtp_pkg and the rtl top level; holds its own profile predictor
`timescale 1ns / 1ps

module tb_nested_region_time_profiler;
	import nrtp_pkg::*;

	localparam logic [TIME_W-1:0] T_MAX = '1;
	localparam logic [TIME_W-1:0] T0    = '0;
	localparam logic [TIME_W-1:0] T1    = 64'd1;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] calls;
		logic [TIME_W-1:0] total;
		logic [TIME_W-1:0] excl;
		logic [TIME_W-1:0] elapsed;
	} report_t;

	typedef struct {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] ts;
		bit                typed;
		report_t           exp;
	} script_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        operation;
	logic [SLOT_W-1:0] slot;
	logic [TIME_W-1:0] timestamp;
	logic              done;
	logic [1:0]        status;
	logic [SLOT_W-1:0] result_slot;
	logic [TIME_W-1:0] num_calls;
	logic [TIME_W-1:0] total_time;
	logic [TIME_W-1:0] self_time;
	logic [TIME_W-1:0] elapsed_time;

	// profiler state as predicted
	logic [SLOT_W-1:0] stk_slot  [STACK_DEPTH_DEF];
	logic [TIME_W-1:0] stk_start [STACK_DEPTH_DEF];
	logic [TIME_W-1:0] stk_child [STACK_DEPTH_DEF];
	int unsigned       depth;
	logic [DROP_W-1:0] drops;
	stats_t            stats [SLOT_COUNT_DEF];

	report_t           pending_reports [$];
	script_row_t       script [$];
	int                fails = 0;
	logic [TIME_W-1:0] now_ns;

	nested_region_time_profiler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.slot         (slot),
		.timestamp    (timestamp),
		.done         (done),
		.status       (status),
		.result_slot  (result_slot),
		.num_calls    (num_calls),
		.total_time   (total_time),
		.self_time    (self_time),
		.elapsed_time (elapsed_time)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic report_t slot_report(status_t st, logic [SLOT_W-1:0] s,
	                                        logic [TIME_W-1:0] el);
		report_t r;
		r = '0;
		r.status = st;
		r.slot = s;
		if (s < SLOT_COUNT_DEF) begin
			r.calls = stats[s].calls;
			r.total = stats[s].total;
			r.excl  = stats[s].excl;
		end
		r.elapsed = el;
		return r;
	endfunction

	function automatic void wipe_profile();
		for (int i = 0; i < SLOT_COUNT_DEF; i++)
			stats[i] = '0;
		depth = 0;
		drops = '0;
	endfunction

	function automatic report_t profile_step(op_t op, logic [SLOT_W-1:0] s,
	                                         logic [TIME_W-1:0] now);
		report_t           r;
		logic [SLOT_W-1:0] fs;
		logic [TIME_W-1:0] el;
		logic [TIME_W-1:0] ch;
		logic [TIME_W-1:0] excl;
		r = '0;
		r.status = ST_DONE;
		case (op)
			OP_ENTER: begin
				if (depth >= STACK_DEPTH_DEF) begin
					if (drops != DROP_MAX)
						drops++;
					r = slot_report(ST_ENTER_DROP, s, '0);
				end else begin
					stk_slot[depth]  = s;
					stk_start[depth] = now;
					stk_child[depth] = '0;
					depth++;
					r = slot_report(ST_DONE, s, '0);
				end
			end
			OP_EXIT: begin
				if (drops != '0) begin
					// matches an enter that was dropped on a full stack
					drops--;
					r.status = ST_EXIT_IGNORED;
				end else if (depth == 0) begin
					r.status = ST_EXIT_IGNORED;
				end else begin
					depth--;
					fs = stk_slot[depth];
					el = now - stk_start[depth];
					ch = stk_child[depth];
					excl = (el >= ch) ? el - ch : '0;
					if (fs < SLOT_COUNT_DEF) begin
						stats[fs].calls += 1;
						stats[fs].total += el;
						stats[fs].excl  += excl;
					end
					if (depth > 0)
						stk_child[depth-1] += el;
					r = slot_report(ST_DONE, fs, el);
				end
			end
			OP_READ: r = slot_report(ST_DONE, s, '0);
			default: wipe_profile();
		endcase
		return r;
	endfunction

	function automatic script_row_t mk_row(op_t op, logic [SLOT_W-1:0] s,
	                                       logic [TIME_W-1:0] ts, bit typed,
	                                       status_t st, logic [SLOT_W-1:0] rs,
	                                       logic [TIME_W-1:0] c, t, x, e);
		script_row_t row;
		row.op = op;
		row.slot = s;
		row.ts = ts;
		row.typed = typed;
		row.exp.status = st;
		row.exp.slot = rs;
		row.exp.calls = c;
		row.exp.total = t;
		row.exp.excl = x;
		row.exp.elapsed = e;
		return row;
	endfunction

	// present one request, hold it until taken, then queue its expected report
	task automatic issue(op_t op, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] ts,
	                     int idle_pct, bit typed, report_t typed_exp);
		report_t rep;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		slot      <= s;
		timestamp <= ts;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		rep = profile_step(op, s, ts);
		pending_reports.push_back(typed ? typed_exp : rep);
	endtask

	task automatic drain_reports();
		@(negedge clk);
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int count, int idle_pct);
		int                left;
		int                enter_pct;
		int                pick;
		op_t               op;
		logic [TIME_W-1:0] ts;
		left = 0;
		enter_pct = 50;
		for (int n = 0; n < count; n++) begin
			// bursts with a bias toward deep nesting or toward unwinding
			if (left == 0) begin
				left = $urandom_range(96, 16);
				case ($urandom_range(4))
					0:       enter_pct = 20;
					1:       enter_pct = 45;
					2:       enter_pct = 55;
					3:       enter_pct = 80;
					default: enter_pct = 97;
				endcase
			end
			left--;
			pick = $urandom_range(999);
			if (pick < 8)
				op = OP_CLEAR;
			else if (pick < 100)
				op = OP_READ;
			else if ($urandom_range(99) < enter_pct)
				op = OP_ENTER;
			else
				op = OP_EXIT;
			if ($urandom_range(15) == 0)
				now_ns = {$urandom, $urandom};
			else
				now_ns += $urandom_range(300);
			ts = (op == OP_ENTER || op == OP_EXIT) ? now_ns : {$urandom, $urandom};
			issue(op, SLOT_W'($urandom_range(31)), ts, idle_pct, 1'b0, '0);
		end
	endtask

	// check each result against the oldest outstanding request
	always @(posedge clk) begin
		report_t got;
		report_t exp;
		if (arst_n === 1'b1 && done === 1'b1) begin
			got.status  = status_t'(status);
			got.slot    = result_slot;
			got.calls   = num_calls;
			got.total   = total_time;
			got.excl    = self_time;
			got.elapsed = elapsed_time;
			if (pending_reports.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
			end else begin
				exp = pending_reports.pop_front();
				if (got.status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, got.status);
					fails++;
				end
				if (got.slot !== exp.slot) begin
					$error("result_slot: expected %0d, got %0d", exp.slot, got.slot);
					fails++;
				end
				if (got.calls !== exp.calls) begin
					$error("num_calls: expected %0h, got %0h", exp.calls, got.calls);
					fails++;
				end
				if (got.total !== exp.total) begin
					$error("total_time: expected %0h, got %0h", exp.total, got.total);
					fails++;
				end
				if (got.excl !== exp.excl) begin
					$error("self_time: expected %0h, got %0h", exp.excl, got.excl);
					fails++;
				end
				if (got.elapsed !== exp.elapsed) begin
					$error("elapsed_time: expected %0h, got %0h", exp.elapsed, got.elapsed);
					fails++;
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		operation = '0;
		slot      = '0;
		timestamp = '0;
		wipe_profile();
		now_ns = {$urandom, $urandom};

		// typed rows: after reset, wraparound extremes, ignored exits, clear
		script.push_back(mk_row(OP_READ,  5'd0,  T0, 1'b1, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_READ,  5'd31, T_MAX, 1'b1, ST_DONE, 5'd31, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd9,  T0, 1'b1, ST_EXIT_IGNORED, 5'd0,
		                        T0, T0, T0, T0));
		script.push_back(mk_row(OP_ENTER, 5'd31, T_MAX, 1'b1, ST_DONE, 5'd31, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd0,  T0, 1'b1, ST_DONE, 5'd31, T1, T1, T1, T1));
		script.push_back(mk_row(OP_ENTER, 5'd0,  T0, 1'b1, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd5,  T_MAX, 1'b1, ST_DONE, 5'd0, T1, T_MAX, T_MAX,
		                        T_MAX));
		// nesting: child time moves to the parent
		script.push_back(mk_row(OP_ENTER, 5'd3,  64'd100, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_ENTER, 5'd4,  64'd150, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd0,  64'd170, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd0,  64'd200, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		// child longer than parent: self time floors at zero
		script.push_back(mk_row(OP_ENTER, 5'd7,  64'd1000, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_ENTER, 5'd8,  T0, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd0,  64'd900, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd0,  64'd1100, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_READ,  5'd7,  T0, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_READ,  5'd3,  T0, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_ENTER, 5'd2,  64'd50, 1'b0, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_CLEAR, 5'd21, T_MAX, 1'b1, ST_DONE, 5'd0, T0, T0, T0, T0));
		script.push_back(mk_row(OP_READ,  5'd31, T0, 1'b1, ST_DONE, 5'd31, T0, T0, T0, T0));
		script.push_back(mk_row(OP_EXIT,  5'd31, T_MAX, 1'b1, ST_EXIT_IGNORED, 5'd0,
		                        T0, T0, T0, T0));
		script.push_back(mk_row(OP_READ,  5'd0,  T_MAX, 1'b1, ST_DONE, 5'd0, T0, T0, T0, T0));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			issue(script[i].op, script[i].slot, script[i].ts, 38, script[i].typed,
			      script[i].exp);

		run_random(360, 38);
		drain_reports();
		run_random(360, 68);
		drain_reports();
		run_random(360, 0);

		// fill the stack, overflow a few times, match the dropped enters, then unwind
		drain_reports();
		issue(OP_CLEAR, '0, '0, 0, 1'b0, '0);
		for (int i = 0; i < STACK_DEPTH_DEF; i++) begin
			now_ns += $urandom_range(50);
			issue(OP_ENTER, SLOT_W'($urandom_range(31)), now_ns, 0, 1'b0, '0);
		end
		for (int i = 0; i < 5; i++)
			issue(OP_ENTER, SLOT_W'($urandom_range(31)), {$urandom, $urandom}, 0, 1'b0, '0);
		for (int i = 0; i < 5; i++)
			issue(OP_EXIT, SLOT_W'($urandom_range(31)), {$urandom, $urandom}, 0, 1'b0, '0);
		for (int i = 0; i < 6; i++) begin
			now_ns += $urandom_range(500);
			issue(OP_EXIT, '0, now_ns, 0, 1'b0, '0);
		end
		for (int i = 0; i < 4; i++)
			issue(OP_READ, SLOT_W'($urandom_range(31)), '0, 0, 1'b0, '0);

		drain_reports();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
